[rtl/core/fccw_pkg.sv]
package fccw_pkg;

   // Field and register widths
   localparam int unsigned OP_W      = 1;
   localparam int unsigned INDEX_W   = 12;
   localparam int unsigned ENTRY_W   = 32;
   localparam int unsigned OFFSET_W  = 32;
   localparam int unsigned CLUSTER_W = 32;
   localparam int unsigned LBA_W     = 40;
   localparam int unsigned SPC_W     = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_W     = 32;

   // Operation codes of a request word
   localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OP_W-1:0] OP_WALK  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_SECTORS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START_SECTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_THRESHOLD     = 2'd2;

   // Register reset values
   localparam logic [SPC_W-1:0] SPC_RESET           = 8'd8;
   localparam logic [CSR_W-1:0] DATA_START_RESET    = 32'd0;
   localparam logic [CSR_W-1:0] END_THRESHOLD_RESET = 32'd268435446;

   // Cluster numbering starts at two
   localparam logic [LBA_W-1:0] FIRST_DATA_CLUSTER = 40'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic wr_entry;
      logic start;
      logic div_step;
      logic hop;
      logic end_chain;
      logic mult;
      logic load_out;
   } fccw_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_last;
      logic hops_zero;
      logic cur_in_table;
      logic entry_ends;
      logic out_free;
   } fccw_status_type;

endpackage

[rtl/core/fat_cluster_chain_walker.sv]
// Cluster chain walker over an on-chip FAT table.
// Request words (req_valid/req_stall) carry req_op: a write word stores
// req_entry_value at req_entry_index and returns nothing; a walk word follows
// the chain from req_head_cluster for req_byte_offset / (sectors per cluster
// * SECTOR_BYTES) hops and returns one response word (rsp_valid/rsp_stall)
// with the cluster reached, an end flag and the cluster's first sector.
// The user must write registers through csr_wr_en/csr_index/csr_wdata only
// while idle; the block does not enforce it. A walk runs a bit-serial hop
// count division, then per hop a table read through the registered memory
// port and a check, one more check when the count runs out, and a scale
// and load of the response; a chain that ends early stops at the check
// that meets its end.
// Only one walk is in flight; req_stall is high until its response is loaded.
// A response waiting under rsp_stall is held; the next request is still taken
// and its walk runs, waiting only to load its own response.
// Reset clears the control state and restores register defaults; table
// entries are undefined until written. SECTOR_BYTES must be a power of two.
module fat_cluster_chain_walker
   import fccw_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 4096,
   parameter int unsigned SECTOR_BYTES  = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_op,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [ENTRY_W-1:0]    req_entry_value,
   input  logic [INDEX_W-1:0]    req_head_cluster,
   input  logic [OFFSET_W-1:0]   req_byte_offset,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CLUSTER_W-1:0]  rsp_cluster,
   output logic                  rsp_chain_ended,
   output logic [LBA_W-1:0]      rsp_first_sector
);

   fccw_cmd_type    cmd;
   fccw_status_type status;

   fccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fccw_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .SECTOR_BYTES  (SECTOR_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .req_head_cluster  (req_head_cluster),
      .req_byte_offset   (req_byte_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cluster       (rsp_cluster),
      .rsp_chain_ended   (rsp_chain_ended),
      .rsp_first_sector  (rsp_first_sector)
   );

endmodule

[rtl/core/fccw_ctrl.sv]
module fccw_ctrl
   import fccw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_stall,
   input  fccw_status_type status,
   output fccw_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIV    = 6'b000010,
      ST_HOPCHK = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_MULT   = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Take a new word only while no walk is in flight
   assign req_stall = (state_ff != ST_IDLE);

   // Take write words while idle and sequence one walk: divide, hop, scale, hand over
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_WALK) begin
                  cmd.start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  cmd.wr_entry = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_HOPCHK;
            end
         end
         ST_HOPCHK: begin
            priority if (status.hops_zero) begin
               state_in = ST_MULT;
            end else if (!status.cur_in_table) begin
               cmd.end_chain = 1'b1;
               state_in      = ST_MULT;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.entry_ends) begin
               cmd.end_chain = 1'b1;
               state_in      = ST_MULT;
            end else begin
               cmd.hop  = 1'b1;
               state_in = ST_HOPCHK;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/fccw_datapath.sv]
module fccw_datapath
   import fccw_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 4096,
   parameter int unsigned SECTOR_BYTES  = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fccw_cmd_type          cmd,
   output fccw_status_type       status,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [ENTRY_W-1:0]    req_entry_value,
   input  logic [INDEX_W-1:0]    req_head_cluster,
   input  logic [OFFSET_W-1:0]   req_byte_offset,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CLUSTER_W-1:0]  rsp_cluster,
   output logic                  rsp_chain_ended,
   output logic [LBA_W-1:0]      rsp_first_sector
);

   localparam int unsigned AW          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW          = (AW > INDEX_W) ? AW : INDEX_W;
   localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int unsigned QW          = OFFSET_W - SECTOR_SHIFT;
   localparam int unsigned CNT_W       = $clog2(QW);

   // Configuration registers
   logic [SPC_W-1:0] spc_ff;
   logic [CSR_W-1:0] data_start_ff;
   logic [CSR_W-1:0] end_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff           <= SPC_RESET;
         data_start_ff    <= DATA_START_RESET;
         end_threshold_ff <= END_THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CLUSTER_SECTORS:   spc_ff           <= csr_wdata[SPC_W-1:0];
            CSR_DATA_START_SECTOR: data_start_ff    <= csr_wdata;
            CSR_END_THRESHOLD:     end_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Walk state
   logic [CW-1:0]    cur_ff, cur_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [SPC_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ended_ff, ended_in;
   logic [LBA_W-1:0] prod_ff, prod_in;

   // Table store, read every cycle at the current cluster
   logic [ENTRY_W-1:0] fat_table_mem [TABLE_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic               wr_in_table;

   assign wr_addr     = AW'(req_entry_index);
   assign rd_addr     = AW'(cur_ff);
   assign wr_in_table = (32'(req_entry_index) < 32'(TABLE_ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.wr_entry && wr_in_table) begin
         fat_table_mem[wr_addr] <= req_entry_value;
      end
      rd_data_ff <= fat_table_mem[rd_addr];
   end

   // One restoring division step on the hop count; a zero divisor yields no hops
   logic [SPC_W:0] rem_shift;
   logic [SPC_W:0] spc_ext;
   logic           rem_ge;
   logic [SPC_W:0] rem_sub;

   assign rem_shift = {rem_ff, q_ff[QW-1]};
   assign spc_ext   = {1'b0, spc_ff};
   assign rem_ge    = (spc_ff != '0) && (rem_shift >= spc_ext);
   assign rem_sub   = rem_shift - spc_ext;

   // Sector offset of the current cluster
   logic [LBA_W-1:0] cluster_rel;
   assign cluster_rel = LBA_W'(cur_ff) - FIRST_DATA_CLUSTER;

   always_comb begin
      cur_in   = cur_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      ended_in = ended_ff;
      prod_in  = prod_ff;
      if (cmd.start) begin
         cur_in   = CW'(req_head_cluster);
         q_in     = (spc_ff == '0) ? '0 : req_byte_offset[OFFSET_W-1:SECTOR_SHIFT];
         rem_in   = '0;
         cnt_in   = '0;
         ended_in = 1'b0;
      end
      if (cmd.div_step) begin
         rem_in = rem_ge ? rem_sub[SPC_W-1:0] : rem_shift[SPC_W-1:0];
         q_in   = {q_ff[QW-2:0], rem_ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.hop) begin
         cur_in = CW'(rd_data_ff);
         q_in   = q_ff - QW'(1);
      end
      if (cmd.end_chain) begin
         cur_in   = '0;
         ended_in = 1'b1;
      end
      if (cmd.mult) begin
         prod_in = cluster_rel * LBA_W'(spc_ff);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      if (reset) begin
         ended_ff <= 1'b0;
      end else begin
         ended_ff <= ended_in;
      end
   end

   // Status for the controller
   assign status.div_last     = (cnt_ff == CNT_W'(QW - 1));
   assign status.hops_zero    = (q_ff == '0);
   assign status.cur_in_table = (32'(cur_ff) < 32'(TABLE_ENTRIES));
   assign status.entry_ends   = (rd_data_ff == '0)
                              || (rd_data_ff > end_threshold_ff)
                              || (rd_data_ff >= 32'(TABLE_ENTRIES));
   assign status.out_free     = !rsp_valid || !rsp_stall;

   // Output register, holds while the receiver stalls
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CLUSTER_W-1:0] rsp_cluster_ff, rsp_cluster_in;
   logic                 rsp_ended_ff, rsp_ended_in;
   logic [LBA_W-1:0]     rsp_sector_ff, rsp_sector_in;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_ended_in   = rsp_ended_ff;
      rsp_sector_in  = rsp_sector_ff;
      if (cmd.load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_cluster_in = CLUSTER_W'(cur_ff);
         rsp_ended_in   = ended_ff;
         rsp_sector_in  = ended_ff ? '0 : (LBA_W'(data_start_ff) + prod_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_ended_ff   <= rsp_ended_in;
      rsp_sector_ff  <= rsp_sector_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cluster      = rsp_cluster_ff;
   assign rsp_chain_ended  = rsp_ended_ff;
   assign rsp_first_sector = rsp_sector_ff;

endmodule
